>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the ready queue RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk, skipped while rst_n is low.
`define TRQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("trq: assertion failed");

// Check prop at every rising edge of clk, reset included.
`define TRQ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("trq: assertion failed");

`endif

>>> rtl/trq_pkg.sv
// ---------------------------------------------------------------------------
// trq_pkg
// Types and codes shared by the two-level ready queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package trq_pkg;

  localparam int SLOT_W   = 6;
  localparam int SLOT_CAP = 2 ** SLOT_W;

  localparam logic [1:0] MODE_ENQ     = 2'd0;
  localparam logic [1:0] MODE_REM     = 2'd1;
  localparam logic [1:0] MODE_PICK    = 2'd2;
  localparam logic [1:0] MODE_SETPRIO = 2'd3;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_QUEUED     = 2'd1;
  localparam logic [1:0] STAT_NOT_QUEUED = 2'd2;
  localparam logic [1:0] STAT_EMPTY      = 2'd3;

  typedef struct packed {
    logic [1:0]        mode;
    logic [SLOT_W-1:0] slot;
    logic              priority_req;
  } trq_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] chosen_slot;
    logic              chosen_valid;
    logic              chosen_priority;
  } trq_out_t;

  typedef struct packed {
    logic next_we;
    logic prev_we;
  } trq_wen_t;

endpackage

>>> rtl/trq_link_mem.sv
// ---------------------------------------------------------------------------
// trq_link_mem
// Next and prev ring link memories, one write and one registered read each.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module trq_link_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                clk_i,
  input  trq_pkg::trq_wen_t   wen_i,
  input  logic [AW-1:0]       next_waddr_i,
  input  logic [AW-1:0]       next_wdata_i,
  input  logic [AW-1:0]       prev_waddr_i,
  input  logic [AW-1:0]       prev_wdata_i,
  input  logic [AW-1:0]       next_raddr_i,
  input  logic [AW-1:0]       prev_raddr_i,
  output logic [AW-1:0]       next_rdata_o,
  output logic [AW-1:0]       prev_rdata_o
);
  import trq_pkg::*;

  logic [AW-1:0] next_mem [DEPTH];
  logic [AW-1:0] prev_mem [DEPTH];
  logic [AW-1:0] next_rdata_q;
  logic [AW-1:0] prev_rdata_q;

  always_ff @(posedge clk_i) begin
    if (wen_i.next_we) begin
      next_mem[next_waddr_i] <= next_wdata_i;
    end
    next_rdata_q <= next_mem[next_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wen_i.prev_we) begin
      prev_mem[prev_waddr_i] <= prev_wdata_i;
    end
    prev_rdata_q <= prev_mem[prev_raddr_i];
  end

  assign next_rdata_o = next_rdata_q;
  assign prev_rdata_o = prev_rdata_q;

endmodule

>>> rtl/two_level_ready_queue_top.sv
// ---------------------------------------------------------------------------
// two_level_ready_queue_top
// Two circular doubly linked FIFO ready queues (high, normal) over a table
// of task slots: enqueue, remove, pick next and set priority.
// ---------------------------------------------------------------------------
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_stall_o | in_data_i  (trq_in_t)
//   out     | output    | out_valid_o / out_stall_i | out_data_o (trq_out_t)
//
// One transaction at a time: a status-only reply goes from decode straight to
// finish, remove or pick unlinks, enqueue links through S_LK_WR1 and S_LK_WR2
// unless the queue is empty, and a priority move unlinks, then links.
// The link memories have registered reads; each unlink or link reads first,
// then writes, so a read never meets a write to the same entry.
// Reset empties both queues at once; the link memories need no clearing.
// A held result stalls only the finish step; the input waits until idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module two_level_ready_queue_top #(
  parameter int SLOTS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  trq_pkg::trq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output trq_pkg::trq_out_t out_data_o
);
  import trq_pkg::*;

  localparam int DEPTH = (SLOTS < SLOT_CAP) ? SLOTS : SLOT_CAP;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_UL_RD  = 3'd2;
  localparam logic [2:0] S_UL_WR  = 3'd3;
  localparam logic [2:0] S_LK_RD  = 3'd4;
  localparam logic [2:0] S_LK_WR1 = 3'd5;
  localparam logic [2:0] S_LK_WR2 = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0]       state_q, state_d;
  trq_in_t          req_q, req_d;
  logic [AW-1:0]    tgt_q, tgt_d;
  logic             old_lvl_q, old_lvl_d;
  logic             pick_q, pick_d;
  logic             relink_q, relink_d;
  logic [1:0]       status_q, status_d;
  logic [AW-1:0]    head_q [2];
  logic [AW-1:0]    head_d [2];
  logic [1:0]       hv_q, hv_d;
  logic [DEPTH-1:0] inq_q, inq_d;
  logic [DEPTH-1:0] lvl_q, lvl_d;
  logic             out_valid_q, out_valid_d;
  trq_out_t         out_data_q, out_data_d;

  trq_wen_t         wen;
  logic [AW-1:0]    next_waddr, next_wdata, prev_waddr, prev_wdata;
  logic [AW-1:0]    next_raddr, prev_raddr;
  logic [AW-1:0]    next_rdata, prev_rdata;

  logic [AW-1:0]    sidx;
  logic             in_range;
  logic             pq;
  logic             lq;

  assign sidx       = req_q.slot[AW-1:0];
  assign in_range   = int'(req_q.slot) < DEPTH;
  assign pq         = hv_q[0] ? 1'b0 : 1'b1;
  assign lq         = req_q.priority_req;
  assign next_raddr = tgt_q;
  assign prev_raddr = (state_q == S_LK_RD) ? head_q[lq] : tgt_q;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    tgt_d       = tgt_q;
    old_lvl_d   = old_lvl_q;
    pick_d      = pick_q;
    relink_d    = relink_q;
    status_d    = status_q;
    head_d      = head_q;
    hv_d        = hv_q;
    inq_d       = inq_q;
    lvl_d       = lvl_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && out_stall_i;
    wen         = '0;
    next_waddr  = tgt_q;
    next_wdata  = tgt_q;
    prev_waddr  = tgt_q;
    prev_wdata  = tgt_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        pick_d   = 1'b0;
        relink_d = 1'b0;
        status_d = STAT_OK;
        state_d  = S_FINISH;
        priority if (req_q.mode == MODE_PICK) begin
          if (!hv_q[pq]) begin
            status_d = STAT_EMPTY;
          end else begin
            tgt_d     = head_q[pq];
            old_lvl_d = pq;
            pick_d    = 1'b1;
            state_d   = S_UL_RD;
          end
        end else if (!in_range) begin
          status_d = STAT_NOT_QUEUED;
        end else begin
          tgt_d     = sidx;
          old_lvl_d = lvl_q[sidx];
          unique case (req_q.mode)
            MODE_ENQ: begin
              if (inq_q[sidx]) begin
                status_d = STAT_QUEUED;
              end else begin
                lvl_d[sidx] = lq;
                state_d     = S_LK_RD;
              end
            end
            MODE_REM: begin
              if (!inq_q[sidx]) begin
                status_d = STAT_NOT_QUEUED;
              end else begin
                state_d = S_UL_RD;
              end
            end
            MODE_SETPRIO: begin
              if (lvl_q[sidx] != lq) begin
                if (inq_q[sidx]) begin
                  relink_d = 1'b1;
                  state_d  = S_UL_RD;
                end else begin
                  lvl_d[sidx] = lq;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_UL_RD: begin
        state_d = S_UL_WR;
      end
      S_UL_WR: begin
        if (next_rdata == tgt_q) begin
          hv_d[old_lvl_q] = 1'b0;
        end else begin
          wen.prev_we = 1'b1;
          prev_waddr  = next_rdata;
          prev_wdata  = prev_rdata;
          wen.next_we = 1'b1;
          next_waddr  = prev_rdata;
          next_wdata  = next_rdata;
          if (head_q[old_lvl_q] == tgt_q) begin
            head_d[old_lvl_q] = next_rdata;
          end
        end
        inq_d[tgt_q] = 1'b0;
        if (relink_q) begin
          lvl_d[tgt_q] = lq;
          state_d      = S_LK_RD;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_LK_RD: begin
        inq_d[tgt_q] = 1'b1;
        if (!hv_q[lq]) begin
          hv_d[lq]    = 1'b1;
          head_d[lq]  = tgt_q;
          wen.next_we = 1'b1;
          wen.prev_we = 1'b1;
          state_d     = S_FINISH;
        end else begin
          state_d = S_LK_WR1;
        end
      end
      S_LK_WR1: begin
        wen.next_we = 1'b1;
        next_waddr  = prev_rdata;
        next_wdata  = tgt_q;
        wen.prev_we = 1'b1;
        prev_waddr  = tgt_q;
        prev_wdata  = prev_rdata;
        state_d     = S_LK_WR2;
      end
      S_LK_WR2: begin
        wen.prev_we = 1'b1;
        prev_waddr  = head_q[lq];
        prev_wdata  = tgt_q;
        wen.next_we = 1'b1;
        next_waddr  = tgt_q;
        next_wdata  = head_q[lq];
        state_d     = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d                = 1'b1;
          out_data_d.status          = status_q;
          out_data_d.chosen_slot     = pick_q ? SLOT_W'(tgt_q) : '0;
          out_data_d.chosen_valid    = pick_q;
          out_data_d.chosen_priority = pick_q ? old_lvl_q : 1'b0;
          state_d                    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hv_q        <= '0;
      inq_q       <= '0;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hv_q        <= hv_d;
      inq_q       <= inq_d;
      lvl_q       <= lvl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    tgt_q      <= tgt_d;
    old_lvl_q  <= old_lvl_d;
    pick_q     <= pick_d;
    relink_q   <= relink_d;
    status_q   <= status_d;
    head_q     <= head_d;
    out_data_q <= out_data_d;
  end

  trq_link_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_link_mem (
    .clk_i        (clk_i),
    .wen_i        (wen),
    .next_waddr_i (next_waddr),
    .next_wdata_i (next_wdata),
    .prev_waddr_i (prev_waddr),
    .prev_wdata_i (prev_wdata),
    .next_raddr_i (next_raddr),
    .prev_raddr_i (prev_raddr),
    .next_rdata_o (next_rdata),
    .prev_rdata_o (prev_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `TRQ_ASSERT(a_accept_decodes, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> (state_q == S_DECODE))
  `TRQ_ASSERT(a_high_head_queued, clk_i, rst_ni, (state_q == S_IDLE && hv_q[0]) |-> inq_q[head_q[0]])
  `TRQ_ASSERT(a_norm_head_queued, clk_i, rst_ni, (state_q == S_IDLE && hv_q[1]) |-> inq_q[head_q[1]])
  `TRQ_ASSERT(a_pick_ok, clk_i, rst_ni, (out_valid_o && out_data_o.chosen_valid) |-> (out_data_o.status == STAT_OK))
  `TRQ_ASSERT_ALWAYS(a_heads_differ, clk_i, (rst_ni && hv_q[0] && hv_q[1]) |-> (head_q[0] != head_q[1]))

endmodule

>>> test/tb_two_level_ready_queue_top.sv
// ---------------------------------------------------------------------------
// tb_two_level_ready_queue_top
// Self-checking testbench for the two-level ready queue. A local scoreboard
// model tracks both linked queues and predicts every reply. Directed tests
// cover the error codes, FIFO order, priority moves and backpressure. A
// random mix of mostly well-formed transactions follows under varying
// sender and receiver idling.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_two_level_ready_queue_top;

  import trq_pkg::*;

  localparam int NUM_SLOTS   = 64;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 20;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  trq_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  trq_out_t out_data_o;

  two_level_ready_queue_top #(
    .SLOTS(NUM_SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [SLOT_W-1:0] ring_next [NUM_SLOTS];
  logic [SLOT_W-1:0] ring_prev [NUM_SLOTS];
  logic              queued    [NUM_SLOTS];
  logic              level     [NUM_SLOTS];
  logic [SLOT_W-1:0] head      [2];
  logic              head_ok   [2];

  trq_out_t reply_q [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int cycle_count    = 0;
  int sent_count     = 0;
  int reply_count    = 0;
  int pick_count     = 0;
  int error_replies  = 0;
  int fail_count     = 0;

  function automatic void link_at_tail(int s);
    int q;
    int t;
    q = int'(level[s]);
    if (!head_ok[q]) begin
      head[q]      = SLOT_W'(s);
      head_ok[q]   = 1'b1;
      ring_next[s] = SLOT_W'(s);
      ring_prev[s] = SLOT_W'(s);
    end else begin
      t               = int'(ring_prev[head[q]]);
      ring_next[t]    = SLOT_W'(s);
      ring_prev[s]    = SLOT_W'(t);
      ring_prev[head[q]] = SLOT_W'(s);
      ring_next[s]    = head[q];
    end
    queued[s] = 1'b1;
  endfunction

  function automatic void unlink_from_ring(int s);
    int q;
    int n;
    int p;
    q = int'(level[s]);
    n = int'(ring_next[s]);
    p = int'(ring_prev[s]);
    if (n == s) begin
      head_ok[q] = 1'b0;
    end else begin
      ring_prev[n] = SLOT_W'(p);
      ring_next[p] = SLOT_W'(n);
      if (int'(head[q]) == s) begin
        head[q] = SLOT_W'(n);
      end
    end
    queued[s] = 1'b0;
  endfunction

  function automatic trq_out_t predict_reply(trq_in_t item);
    trq_out_t r;
    int       s;
    int       q;
    r = '0;
    s = int'(item.slot);
    r.status = STAT_OK;
    if (item.mode == MODE_PICK) begin
      q = head_ok[0] ? 0 : 1;
      if (!head_ok[q]) begin
        r.status = STAT_EMPTY;
      end else begin
        r.chosen_slot     = head[q];
        r.chosen_valid    = 1'b1;
        r.chosen_priority = q[0];
        unlink_from_ring(int'(head[q]));
      end
    end else if (s >= NUM_SLOTS) begin
      r.status = STAT_NOT_QUEUED;
    end else if (item.mode == MODE_ENQ) begin
      if (queued[s]) begin
        r.status = STAT_QUEUED;
      end else begin
        level[s] = item.priority_req;
        link_at_tail(s);
      end
    end else if (item.mode == MODE_REM) begin
      if (!queued[s]) begin
        r.status = STAT_NOT_QUEUED;
      end else begin
        unlink_from_ring(s);
      end
    end else if (level[s] != item.priority_req) begin
      if (queued[s]) begin
        unlink_from_ring(s);
        level[s] = item.priority_req;
        link_at_tail(s);
      end else begin
        level[s] = item.priority_req;
      end
    end
    return r;
  endfunction

  task automatic send_item(logic [1:0] mode, logic [SLOT_W-1:0] slot, logic prio);
    trq_in_t item;
    item.mode         = mode;
    item.slot         = slot;
    item.priority_req = prio;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    reply_q.push_back(predict_reply(item));
    sent_count++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : check_replies
    trq_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      reply_count++;
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected reply, actual %p", $time, out_data_o);
        fail_count++;
      end else begin
        want = reply_q.pop_front();
        if (want.chosen_valid) pick_count++;
        if (want.status != STAT_OK) error_replies++;
        if (out_data_o.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_data_o.status);
          fail_count++;
        end
        if (out_data_o.chosen_slot !== want.chosen_slot) begin
          $display("%0t: chosen_slot expected %0d actual %0d", $time, want.chosen_slot,
                   out_data_o.chosen_slot);
          fail_count++;
        end
        if (out_data_o.chosen_valid !== want.chosen_valid) begin
          $display("%0t: chosen_valid expected %0d actual %0d", $time, want.chosen_valid,
                   out_data_o.chosen_valid);
          fail_count++;
        end
        if (out_data_o.chosen_priority !== want.chosen_priority) begin
          $display("%0t: chosen_priority expected %0d actual %0d", $time,
                   want.chosen_priority, out_data_o.chosen_priority);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d replies outstanding", $time, reply_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic test_empty_and_errors();
    send_item(MODE_PICK, 6'd0, 1'b0);
    send_item(MODE_REM, 6'd63, 1'b1);
    send_item(MODE_SETPRIO, 6'd5, 1'b1);
    send_item(MODE_ENQ, 6'd0, 1'b0);
    send_item(MODE_ENQ, 6'd0, 1'b1);
  endtask

  task automatic test_queue_order();
    send_item(MODE_ENQ, 6'd63, 1'b1);
    send_item(MODE_ENQ, 6'd5, 1'b1);
    send_item(MODE_ENQ, 6'd42, 1'b0);
    send_item(MODE_PICK, 6'd0, 1'b0);
    send_item(MODE_ENQ, 6'd0, 1'b0);
  endtask

  task automatic test_priority_moves();
    send_item(MODE_SETPRIO, 6'd63, 1'b1);
    send_item(MODE_SETPRIO, 6'd63, 1'b0);
    send_item(MODE_REM, 6'd63, 1'b0);
    send_item(MODE_PICK, 6'd63, 1'b1);
    send_item(MODE_PICK, 6'd0, 1'b0);
    send_item(MODE_PICK, 6'd0, 1'b0);
    send_item(MODE_PICK, 6'd0, 1'b0);
    send_item(MODE_ENQ, 6'd21, 1'b1);
    send_item(MODE_SETPRIO, 6'd21, 1'b0);
    send_item(MODE_REM, 6'd21, 1'b1);
    send_item(MODE_PICK, 6'd21, 1'b1);
    wait_drained();
  endtask

  task automatic test_backpressure();
    int i;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req++;
    for (i = 0; i < 16; i++) begin
      send_item(i % 3 == 2 ? MODE_PICK : MODE_ENQ, 6'(i * 4), 1'(i));
    end
    wait_drained();
  endtask

  task automatic test_random_mix(int count, int snd_pct, int rcv_pct);
    int         i;
    int         k;
    int         r;
    int         enq_pct;
    logic [1:0] m;
    logic [5:0] s;
    logic       want_queued;
    int         pool [$];
    send_idle_pct  = snd_pct;
    recv_stall_pct = rcv_pct;
    enq_pct        = 40;
    for (i = 0; i < count; i++) begin
      if (i % 50 == 0) enq_pct = $urandom_range(20, 60);
      r = $urandom_range(99);
      if (r < enq_pct) m = MODE_ENQ;
      else if (r < enq_pct + (100 - enq_pct) / 3) m = MODE_PICK;
      else if (r < enq_pct + 2 * (100 - enq_pct) / 3) m = MODE_REM;
      else m = MODE_SETPRIO;
      want_queued = (m == MODE_ENQ) ? ($urandom_range(99) < 15) : ($urandom_range(99) < 75);
      pool.delete();
      for (k = 0; k < NUM_SLOTS; k++) begin
        if (queued[k] == want_queued) pool.push_back(k);
      end
      if (pool.size() > 0 && $urandom_range(99) < 85) begin
        s = SLOT_W'(pool[$urandom_range(pool.size() - 1)]);
      end else begin
        s = SLOT_W'($urandom);
      end
      if ($urandom_range(99) < 5) m = 2'($urandom);
      send_item(m, s, 1'($urandom_range(1)));
    end
    wait_drained();
  endtask

  initial begin
    int k;
    for (k = 0; k < NUM_SLOTS; k++) begin
      queued[k] = 1'b0;
      level[k]  = 1'b0;
    end
    head_ok[0] = 1'b0;
    head_ok[1] = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_errors();
    test_queue_order();
    test_priority_moves();
    test_backpressure();
    test_random_mix(600, 35, 57);
    test_random_mix(600, 57, 35);
    test_random_mix(600, 0, 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("Covered %0d transactions over both queues: %0d replies, %0d picks,",
             sent_count, reply_count, pick_count);
    $display("%0d error-status replies, one long output hold, %0d cycles.",
             error_replies, cycle_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/trq_pkg.sv
rtl/trq_link_mem.sv
rtl/two_level_ready_queue_top.sv
test/tb_two_level_ready_queue_top.sv
